// ----- rtl/lsd_pkg.sv -----
// ----------------------------------------------------------------------------
// LED strip driver package
// Shared constants, types and a helper function of the frame loader and encoder.
// ----------------------------------------------------------------------------
package lsd_pkg;

  // Strip size and colour store addressing
  localparam int unsigned LED_COUNT  = 144;
  localparam int unsigned LED_ADDR_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int unsigned NUM_LANES  = 3;
  localparam int unsigned LANE_W     = 2;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned POS_W      = 8;
  localparam int unsigned BITPOS_W   = 3;
  localparam int unsigned SLOT_W     = 16;

  // Colour byte lanes within one LED
  localparam logic [LANE_W-1:0] LANE_GREEN    = 2'd0;
  localparam logic [LANE_W-1:0] LANE_RED      = 2'd1;
  localparam logic [LANE_W-1:0] LANE_BLUE     = 2'd2;
  localparam logic [LANE_W-1:0] LANE_RESERVED = 2'd3;

  localparam logic [BITPOS_W-1:0] BIT_MSB = 3'd7;
  localparam logic [BITPOS_W-1:0] BIT_LSB = 3'd0;

  // Command ids and replies
  localparam logic [BYTE_W-1:0] ID_SET_MULTIPLE = 8'h02;
  localparam logic [BYTE_W-1:0] ACK_OK          = 8'hAA;

  // Result kinds
  localparam logic KIND_SYMBOL = 1'b0;
  localparam logic KIND_ACK    = 1'b1;

  // High time as a fraction of the slot: floor(p * duty / 100) computed as
  // (p * ceil(duty * 2^F / 100)) >> F, exact for every 16-bit period.
  localparam int unsigned DUTY_LOW   = 33;
  localparam int unsigned DUTY_HIGH  = 66;
  localparam int unsigned FRAC_W     = 23;
  localparam int unsigned PROD_W     = SLOT_W + FRAC_W;
  localparam logic [FRAC_W-1:0] RECIP_LOW  =
    FRAC_W'((DUTY_LOW  * (64'd1 << FRAC_W) + 64'd99) / 64'd100);
  localparam logic [FRAC_W-1:0] RECIP_HIGH =
    FRAC_W'((DUTY_HIGH * (64'd1 << FRAC_W) + 64'd99) / 64'd100);

  localparam logic [SLOT_W-1:0] SLOT_PERIOD_RESET = 16'd125;

  function automatic logic [SLOT_W-1:0] high_time(input logic [SLOT_W-1:0] period,
                                                   input logic [FRAC_W-1:0] recip);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(period) * PROD_W'(recip);
    return prod[PROD_W-1:FRAC_W];
  endfunction

  localparam logic [SLOT_W-1:0] HIGH_LOW_RESET  = high_time(SLOT_PERIOD_RESET, RECIP_LOW);
  localparam logic [SLOT_W-1:0] HIGH_HIGH_RESET = high_time(SLOT_PERIOD_RESET, RECIP_HIGH);

  // Colour store write request
  typedef struct packed {
    logic                  en;
    logic [LANE_W-1:0]     lane;
    logic [LED_ADDR_W-1:0] addr;
    logic [BYTE_W-1:0]     data;
  } store_wr_t;

  // Colour store read request
  typedef struct packed {
    logic                  en;
    logic [LED_ADDR_W-1:0] addr;
  } store_rd_t;

  // Bit symbol selected by the encoder for the current tick
  typedef struct packed {
    logic                emit;
    logic                last;
    logic [LANE_W-1:0]   lane;
    logic [BITPOS_W-1:0] bitpos;
  } symbol_t;

endpackage

// ----- rtl/lsd_if.sv -----
// ----------------------------------------------------------------------------
// LED strip driver channels
// Valid/ready channels for input items, results and the slot period write.
// ----------------------------------------------------------------------------
interface lsd_item_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] rx_byte;

  modport source (output valid, output op, output rx_byte, input ready);
  modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

interface lsd_result_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] high_count;
  logic        bit_value;
  logic [7:0]  ack_byte;
  logic        frame_end;

  modport source (output valid, output kind, output high_count, output bit_value,
                  output ack_byte, output frame_end, input ready);
  modport sink   (input valid, input kind, input high_count, input bit_value,
                  input ack_byte, input frame_end, output ready);
endinterface

interface lsd_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] slot_period;

  modport source (output valid, output slot_period, input ready);
  modport sink   (input valid, input slot_period, output ready);
endinterface

// ----- rtl/led_strip_frame_loader_and_bit_encoder.sv -----
// ----------------------------------------------------------------------------
// LED strip frame loader and bit encoder
// Loads LED colours from host commands and encodes one strip bit per tick.
// ----------------------------------------------------------------------------
// Usage:
//   item   : input transfers. op 0 carries a received host byte (rx_byte),
//            op 1 is one bit-slot tick of the strip timer.
//   result : at most one transfer per item. kind 1 is the acknowledge byte
//            0xAA sent when a colour load completes; kind 0 is a bit symbol
//            with its high time in timer counts and a frame_end flag.
//   cfg    : writes slot_period; always ready. Both high times are worked
//            out at the write, so a write must land while the block is idle.
// Pipeline: an accepted item passes the middle stage (store read / command
//   update), then the result register, which raises result.valid; a full
//   result register that is not being taken holds the item back.
// Throughput: one item per cycle once the store is clear. The input stays
//   ready while the result register is free or being emptied; a stalled
//   receiver backs up through one middle stage and then drops item.ready.
// Reset (rst, synchronous): command parser back to header gathering, no
//   frame active or pending, slot period 125. The colour store is then
//   zeroed one LED per cycle, all 144 LEDs, with item.ready low.
// ----------------------------------------------------------------------------
module led_strip_frame_loader_and_bit_encoder import lsd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  lsd_cfg_if.sink             cfg,
  lsd_item_if.sink            item,
  lsd_result_if.source        result
);

  // Pre-computed high times for a 0 bit and a 1 bit
  logic [SLOT_W-1:0] high_low;
  logic [SLOT_W-1:0] high_high;

  logic      item_acc;
  logic      adv;

  store_wr_t wr;
  store_rd_t rd;
  symbol_t   sym;
  logic      ack;
  logic [NUM_LANES*BYTE_W-1:0] colour;
  logic      store_busy;

  // Middle stage: holds the item's control while the store read completes
  logic                s1_valid;
  logic                s1_ack;
  logic                s1_last;
  logic [LANE_W-1:0]   s1_lane;
  logic [BITPOS_W-1:0] s1_bitpos;

  logic [BYTE_W-1:0]   lane_byte;
  logic                bit_sel;

  // Result register
  logic                out_valid;
  logic                out_kind;
  logic [SLOT_W-1:0]   out_high_count;
  logic                out_bit_value;
  logic [BYTE_W-1:0]   out_ack_byte;
  logic                out_frame_end;

  // ---------------------------------------------------------------------------
  // Configuration: one multiply each, straight into the high-time registers
  // ---------------------------------------------------------------------------
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      high_low  <= HIGH_LOW_RESET;
      high_high <= HIGH_HIGH_RESET;
    end else if (cfg.valid) begin
      high_low  <= high_time(cfg.slot_period, RECIP_LOW);
      high_high <= high_time(cfg.slot_period, RECIP_HIGH);
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: result register moves when empty or being taken; the middle
  // stage takes a new item when empty or moving on, once the store is clear.
  // ---------------------------------------------------------------------------
  assign adv        = !out_valid || result.ready;
  assign item.ready = !store_busy && (!s1_valid || adv);
  assign item_acc   = item.valid && item.ready;

  // ---------------------------------------------------------------------------
  // Command parsing, frame sequencing and the colour store
  // ---------------------------------------------------------------------------
  lsd_loader u_loader (
    .clk     (clk),
    .rst     (rst),
    .accept  (item_acc && !item.op),
    .rx_byte (item.rx_byte),
    .wr      (wr),
    .ack     (ack)
  );

  lsd_encoder u_encoder (
    .clk       (clk),
    .rst       (rst),
    .tick      (item_acc && item.op),
    .frame_req (ack),
    .rd        (rd),
    .sym       (sym)
  );

  lsd_store u_store (
    .clk    (clk),
    .rst    (rst),
    .wr     (wr),
    .rd     (rd),
    .colour (colour),
    .busy   (store_busy)
  );

  // ---------------------------------------------------------------------------
  // Middle stage. Store read data holds with it, as a read is only issued
  // when a tick is transferred.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item_acc && (ack || sym.emit);
    end
  end

  always_ff @(posedge clk) begin
    if (item.ready) begin
      s1_ack    <= ack;
      s1_last   <= sym.last;
      s1_lane   <= sym.lane;
      s1_bitpos <= sym.bitpos;
    end
  end

  // Colour bit: lane byte, then MSB-first bit within it
  always_comb begin
    unique case (s1_lane)
      LANE_GREEN: lane_byte = colour[0*BYTE_W +: BYTE_W];
      LANE_RED:   lane_byte = colour[1*BYTE_W +: BYTE_W];
      LANE_BLUE:  lane_byte = colour[2*BYTE_W +: BYTE_W];
      default:    lane_byte = '0;
    endcase
  end

  assign bit_sel = lane_byte[s1_bitpos];

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      if (s1_ack) begin
        out_kind       <= KIND_ACK;
        out_high_count <= '0;
        out_bit_value  <= 1'b0;
        out_ack_byte   <= ACK_OK;
        out_frame_end  <= 1'b0;
      end else begin
        out_kind       <= KIND_SYMBOL;
        out_high_count <= bit_sel ? high_high : high_low;
        out_bit_value  <= bit_sel;
        out_ack_byte   <= '0;
        out_frame_end  <= s1_last;
      end
    end
  end

  assign result.valid      = out_valid;
  assign result.kind       = out_kind;
  assign result.high_count = out_high_count;
  assign result.bit_value  = out_bit_value;
  assign result.ack_byte   = out_ack_byte;
  assign result.frame_end  = out_frame_end;

endmodule

// ----- rtl/lsd_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lsd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/lsd_store.sv -----
// ----------------------------------------------------------------------------
// Colour store
// One RAM per colour lane; every entry is zeroed by a clearing pass after reset.
// ----------------------------------------------------------------------------
module lsd_store import lsd_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  store_wr_t                     wr,
  input  store_rd_t                     rd,
  output logic [NUM_LANES*BYTE_W-1:0]   colour,
  output logic                          busy
);

  logic                  clearing;
  logic [LED_ADDR_W-1:0] clr_addr;
  logic [LED_ADDR_W-1:0] ram_addr;
  logic [BYTE_W-1:0]     ram_data;

  // One LED per cycle, all LED_COUNT entries after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == LED_ADDR_W'(LED_COUNT - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + LED_ADDR_W'(1);
    end
  end

  assign busy     = clearing;
  assign ram_addr = clearing ? clr_addr : wr.addr;
  assign ram_data = clearing ? '0 : wr.data;

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    logic              lane_we;
    logic [BYTE_W-1:0] lane_data;

    assign lane_we = clearing || (wr.en && (wr.lane == LANE_W'(g)));

    lsd_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (LED_COUNT)
    ) u_ram (
      .clk     (clk),
      .wr_en   (lane_we),
      .wr_addr (ram_addr),
      .wr_data (ram_data),
      .rd_en   (rd.en),
      .rd_addr (rd.addr),
      .rd_data (lane_data)
    );

    assign colour[g*BYTE_W +: BYTE_W] = lane_data;
  end

endmodule

// ----- rtl/lsd_loader.sv -----
// ----------------------------------------------------------------------------
// Command loader
// Gathers four header bytes, then writes set-multiple data to the colour store.
// ----------------------------------------------------------------------------
module lsd_loader import lsd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [BYTE_W-1:0] rx_byte,
  output store_wr_t         wr,
  output logic              ack
);

  logic              in_data_phase;
  logic [1:0]        header_bytes_seen;
  logic [15:0]       header_word;
  logic [IDX_W-1:0]  data_byte_index;
  logic [IDX_W-1:0]  final_byte_index;

  logic [BYTE_W-1:0] count;
  logic              id_ok;
  logic [IDX_W-1:0]  final_next;
  logic              done;
  logic [POS_W-1:0]  led;
  logic [LANE_W-1:0] lane;

  assign count = header_word[15:8];
  assign id_ok = header_word[7:0] == ID_SET_MULTIPLE;
  assign led   = data_byte_index[IDX_W-1:2];
  assign lane  = data_byte_index[1:0];

  // Last data byte index is latched on the first data byte
  always_comb begin
    if (data_byte_index != '0) begin
      final_next = final_byte_index;
    end else if (count == '0) begin
      final_next = '0;
    end else begin
      final_next = {count, 2'b00} - IDX_W'(1);
    end
  end

  assign done = in_data_phase && id_ok && (data_byte_index >= final_next);
  assign ack  = accept && done;

  // Reserved lane and LEDs beyond the store are dropped
  assign wr.en   = accept && in_data_phase && id_ok && (count != '0)
                   && (led < POS_W'(LED_COUNT)) && (lane != LANE_RESERVED);
  assign wr.lane = lane;
  assign wr.addr = led[LED_ADDR_W-1:0];
  assign wr.data = rx_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_data_phase     <= 1'b0;
      header_bytes_seen <= '0;
      header_word       <= '0;
      data_byte_index   <= '0;
      final_byte_index  <= '0;
    end else if (accept) begin
      if (!in_data_phase) begin
        header_word       <= {header_word[7:0], rx_byte};
        header_bytes_seen <= header_bytes_seen + 2'd1;
        if (header_bytes_seen == 2'd3) begin
          in_data_phase   <= 1'b1;
          data_byte_index <= '0;
        end
      end else if (!id_ok) begin
        in_data_phase   <= 1'b0;
        data_byte_index <= '0;
      end else begin
        final_byte_index <= final_next;
        if (done) begin
          in_data_phase   <= 1'b0;
          data_byte_index <= '0;
        end else begin
          data_byte_index <= data_byte_index + IDX_W'(1);
        end
      end
    end
  end

endmodule

// ----- rtl/lsd_encoder.sv -----
// ----------------------------------------------------------------------------
// Frame encoder
// Steps LEDs, lanes and bits on each frame tick and issues the store read.
// ----------------------------------------------------------------------------
module lsd_encoder import lsd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      tick,
  input  logic      frame_req,
  output store_rd_t rd,
  output symbol_t   sym
);

  logic                frame_active;
  logic                frame_requested;
  logic [POS_W-1:0]    led_position;
  logic [LANE_W-1:0]   colour_byte_position;
  logic [BITPOS_W-1:0] bit_position;

  logic                start;
  logic                emit;
  logic                last;
  logic [POS_W-1:0]    cur_led;
  logic [LANE_W-1:0]   cur_lane;
  logic [BITPOS_W-1:0] cur_bit;

  assign start = !frame_active && frame_requested;
  assign emit  = tick && (frame_active || frame_requested);

  assign cur_led  = start ? '0 : led_position;
  assign cur_lane = start ? LANE_GREEN : colour_byte_position;
  assign cur_bit  = start ? BIT_MSB : bit_position;

  assign last = (cur_led >= POS_W'(LED_COUNT - 1)) && (cur_lane >= LANE_BLUE)
                && (cur_bit == BIT_LSB);

  assign rd.en   = emit;
  assign rd.addr = (cur_led < POS_W'(LED_COUNT)) ? cur_led[LED_ADDR_W-1:0] : '0;

  assign sym.emit   = emit;
  assign sym.last   = last;
  assign sym.lane   = cur_lane;
  assign sym.bitpos = cur_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_active         <= 1'b0;
      frame_requested      <= 1'b0;
      led_position         <= '0;
      colour_byte_position <= LANE_GREEN;
      bit_position         <= BIT_MSB;
    end else begin
      if (frame_req) begin
        frame_requested <= 1'b1;
      end
      if (emit) begin
        if (start) begin
          frame_active    <= 1'b1;
          frame_requested <= 1'b0;
        end
        if (last) begin
          frame_active         <= 1'b0;
          led_position         <= '0;
          colour_byte_position <= LANE_GREEN;
          bit_position         <= BIT_MSB;
        end else if (cur_bit != BIT_LSB) begin
          led_position         <= cur_led;
          colour_byte_position <= cur_lane;
          bit_position         <= cur_bit - BITPOS_W'(1);
        end else begin
          bit_position <= BIT_MSB;
          if (cur_lane < LANE_BLUE) begin
            led_position         <= cur_led;
            colour_byte_position <= cur_lane + LANE_W'(1);
          end else begin
            led_position         <= cur_led + POS_W'(1);
            colour_byte_position <= LANE_GREEN;
          end
        end
      end
    end
  end

endmodule
